// ===== hw/rtl/tpq_pkg.sv =====
// Shared types and constants for the priority transmit queue.
package tpq_pkg;

  localparam int SLOTS_DEF       = 8;
  localparam int MAX_PAYLOAD_DEF = 32;

  localparam int IN_DATA_W  = 56;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 136;
  localparam int OUT_USER_W = 3;

  typedef enum logic [1:0] {
    KIND_PUSH = 2'd0,
    KIND_BYTE = 2'd1,
    KIND_POP  = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EVICTED  = 3'd1,
    ST_TOO_LONG = 3'd2,
    ST_FULL     = 3'd3,
    ST_POPPED   = 3'd4,
    ST_EMPTY    = 3'd5
  } status_t;

  localparam logic [1:0] PRIO_HIGH = 2'd2;

  // Scan sequencing between top level and scan unit.
  typedef struct packed {
    logic start;
    logic step;
  } scan_ctl_t;

endpackage

// ===== hw/rtl/tpq_scan_unit.sv =====
// Shared compare unit: walks the slots one per cycle, tracks free, victim and winner.
module tpq_scan_unit #(
  parameter int SLOTS = tpq_pkg::SLOTS_DEF,
  parameter int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic               clk,
  input  tpq_pkg::scan_ctl_t ctl,
  input  logic [SW-1:0]      idx,
  input  logic               used,
  input  logic [1:0]         prio,
  input  logic [31:0]        stamp,
  input  logic [31:0]        dest,
  input  logic               ack,
  input  logic [6:0]         len,
  input  logic [6:0]         fill,
  output logic               free_found,
  output logic [SW-1:0]      free_idx,
  output logic [1:0]         w_prio,
  output logic [SW-1:0]      w_idx,
  output logic               any_used,
  output logic [SW-1:0]      b_idx,
  output logic [1:0]         b_prio,
  output logic [31:0]        b_dest,
  output logic               b_ack,
  output logic [6:0]         b_len,
  output logic [6:0]         b_fill
);

  logic        free_r, any_r;
  logic [SW-1:0] free_idx_r, w_idx_r, b_idx_r;
  logic [1:0]  w_prio_r, b_prio_r;
  logic [31:0] w_stamp_r, b_stamp_r, b_dest_r;
  logic        b_ack_r;
  logic [6:0]  b_len_r, b_fill_r;
  logic        w_take, b_take;

  // two comparisons per slot: lowest priority for the victim, highest for the winner, older stamp on a tie
  assign w_take = used && (!any_r || prio < w_prio_r ||
                           (prio == w_prio_r && stamp < w_stamp_r));
  assign b_take = used && (!any_r || prio > b_prio_r ||
                           (prio == b_prio_r && stamp < b_stamp_r));

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      free_r <= 1'b0;
      any_r  <= 1'b0;
    end else if (ctl.step) begin
      if (!free_r && !used) begin
        free_r     <= 1'b1;
        free_idx_r <= idx;
      end
      if (used) any_r <= 1'b1;
      if (w_take) begin
        w_prio_r  <= prio;
        w_stamp_r <= stamp;
        w_idx_r   <= idx;
      end
      if (b_take) begin
        b_prio_r  <= prio;
        b_stamp_r <= stamp;
        b_idx_r   <= idx;
        b_dest_r  <= dest;
        b_ack_r   <= ack;
        b_len_r   <= len;
        b_fill_r  <= fill;
      end
    end
  end

  assign free_found = free_r;
  assign free_idx   = free_idx_r;
  assign w_prio     = w_prio_r;
  assign w_idx      = w_idx_r;
  assign any_used   = any_r;
  assign b_idx      = b_idx_r;
  assign b_prio     = b_prio_r;
  assign b_dest     = b_dest_r;
  assign b_ack      = b_ack_r;
  assign b_len      = b_len_r;
  assign b_fill     = b_fill_r;

endmodule

// ===== hw/rtl/tpq_payload_mem.sv =====
// Payload byte store: one write port, one registered read port.
module tpq_payload_mem #(
  parameter int AW = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [0:(1<<AW)-1];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/priority_tx_queue_with_eviction.sv =====
// Top level of the slot-based priority transmit queue with eviction.
//
// channel  direction  handshake          tuser            tdata
// in_      slave      in_tvalid/tready   kind             push header, payload byte
// out_     master     out_tvalid/tready  status           popped header, byte, counts
//
// A payload byte request is taken in the idle state. A push or pop request scans all slots
// through one shared compare unit, then decides and registers the result; an over-long
// push skips the scan. A pop then emits each byte by memory read, output load and hold.
// Synchronous active-low reset empties all slots; payload memory is not cleared,
// a per-slot fill count makes unwritten bytes read as zero.
// in_tready is low while a request is in work; a stalled output holds the sequencer.
module priority_tx_queue_with_eviction #(
  parameter int SLOTS       = tpq_pkg::SLOTS_DEF,
  parameter int MAX_PAYLOAD = tpq_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // dest_node[31:0], priority_req[33:32], ack_flag[34],
  // msg_len[42:35], data_byte[50:43]
  input  logic [tpq_pkg::IN_DATA_W-1:0]  in_tdata,
  // kind[1:0]
  input  logic [tpq_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // out_destination[31:0], out_priority[33:32], out_ack[34], out_length[41:35],
  // out_byte[49:42], count_low[56:50], count_normal[63:57], count_high[70:64],
  // rejected_total[102:71], evicted_total[134:103]
  output logic [tpq_pkg::OUT_DATA_W-1:0] out_tdata,
  // status[2:0]
  output logic [tpq_pkg::OUT_USER_W-1:0] out_tuser,
  output logic                           out_tlast
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int BW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int AW = SW + BW;
  localparam logic [6:0] MAXP = 7'(MAX_PAYLOAD);
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);
  localparam int OUT_DATA_W_L = tpq_pkg::OUT_DATA_W;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_DECIDE = 7'b0000100,
    S_LOAD   = 7'b0001000,
    S_RD     = 7'b0010000,
    S_BYTE   = 7'b0100000,
    S_HOLD   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // slot metadata
  logic        used_r  [SLOTS];
  logic [1:0]  prio_r  [SLOTS];
  logic [31:0] stamp_r [SLOTS];
  logic [31:0] dest_r  [SLOTS];
  logic        ack_r   [SLOTS];
  logic [6:0]  len_r   [SLOTS];
  logic [6:0]  fill_r  [SLOTS];

  logic [31:0] arrival_r, rej_r, evc_r;
  logic [6:0]  cnt_r [3];
  logic        pend_r;
  logic [SW-1:0] pslot_r;
  logic [6:0]  pidx_r, plen_r;

  // captured request
  logic        is_pop_r;
  logic [31:0] i_dest_r;
  logic [1:0]  i_prio_r;
  logic        i_ack_r;
  logic [6:0]  i_len_r;

  // pending result
  logic [2:0]  res_status_r;
  logic [31:0] res_dest_r;
  logic [1:0]  res_prio_r;
  logic        res_ack_r;
  logic [6:0]  res_len_r;
  logic [6:0]  k_r;
  logic [SW-1:0] scan_i_r;

  // output register
  logic        out_valid_r, out_last_r;
  logic [2:0]  o_status_r;
  logic [OUT_DATA_W_L-1:0] o_data_r;

  logic              accept, out_free, out_load;
  tpq_pkg::kind_t    kind;
  logic [1:0]        in_prio;
  logic [7:0]        in_len;
  logic              byte_wr;
  tpq_pkg::scan_ctl_t sctl;

  logic          s_free, s_any, s_ack;
  logic [SW-1:0] s_free_idx, s_w_idx, s_b_idx;
  logic [1:0]    s_w_prio, s_b_prio;
  logic [31:0]   s_dest;
  logic [6:0]    s_len, s_fill;
  logic [7:0]    rd_byte;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign out_load  = out_free && (state_r == S_LOAD || state_r == S_BYTE);
  assign kind      = tpq_pkg::kind_t'(in_tuser);
  assign in_prio   = (in_tdata[33:32] == 2'd3) ? tpq_pkg::PRIO_HIGH : in_tdata[33:32];
  assign in_len    = in_tdata[42:35];
  assign byte_wr   = accept && kind == tpq_pkg::KIND_BYTE && pend_r && pidx_r < plen_r;

  assign sctl.start = accept;
  assign sctl.step  = (state_r == S_SCAN);

  tpq_scan_unit #(.SLOTS(SLOTS), .SW(SW)) u_scan (
    .clk        (clk),
    .ctl        (sctl),
    .idx        (scan_i_r),
    .used       (used_r[scan_i_r]),
    .prio       (prio_r[scan_i_r]),
    .stamp      (stamp_r[scan_i_r]),
    .dest       (dest_r[scan_i_r]),
    .ack        (ack_r[scan_i_r]),
    .len        (len_r[scan_i_r]),
    .fill       (fill_r[scan_i_r]),
    .free_found (s_free),
    .free_idx   (s_free_idx),
    .w_prio     (s_w_prio),
    .w_idx      (s_w_idx),
    .any_used   (s_any),
    .b_idx      (s_b_idx),
    .b_prio     (s_b_prio),
    .b_dest     (s_dest),
    .b_ack      (s_ack),
    .b_len      (s_len),
    .b_fill     (s_fill)
  );

  tpq_payload_mem #(.AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (byte_wr),
    .wr_addr ({pslot_r, pidx_r[BW-1:0]}),
    .wr_data (in_tdata[50:43]),
    .rd_en   (state_r == S_RD),
    .rd_addr ({s_b_idx, k_r[BW-1:0]}),
    .rd_data (rd_byte)
  );

  // decide outcome
  logic          push_ok, push_evict;
  logic [SW-1:0] push_slot;
  always_comb begin
    push_ok    = s_free || (s_any && s_w_prio < i_prio_r);
    push_evict = !s_free;
    push_slot  = s_free ? s_free_idx : s_w_idx;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (kind == tpq_pkg::KIND_POP) state_nxt = S_SCAN;
          else if (kind == tpq_pkg::KIND_PUSH)
            state_nxt = (in_len > {1'b0, MAXP}) ? S_LOAD : S_SCAN;
        end
      end
      S_SCAN:   if (scan_i_r == LAST_SLOT) state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = (is_pop_r && s_any && s_len != 7'd0) ? S_RD : S_LOAD;
      S_LOAD:   if (out_free) state_nxt = S_IDLE;
      S_RD:     state_nxt = S_BYTE;
      S_BYTE:   if (out_free) state_nxt = (k_r + 7'd1 == s_len) ? S_IDLE : S_HOLD;
      S_HOLD:   state_nxt = S_RD;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      arrival_r   <= 32'd1;
      rej_r       <= '0;
      evc_r       <= '0;
      pend_r      <= 1'b0;
      pslot_r     <= '0;
      pidx_r      <= '0;
      out_valid_r <= 1'b0;
      scan_i_r    <= '0;
      for (int j = 0; j < 3; j++) cnt_r[j] <= '0;
      for (int s = 0; s < SLOTS; s++) begin
        used_r[s] <= 1'b0;
        prio_r[s] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          scan_i_r <= '0;
          if (accept) begin
            is_pop_r <= (kind == tpq_pkg::KIND_POP);
            i_dest_r <= in_tdata[31:0];
            i_prio_r <= in_prio;
            i_ack_r  <= in_tdata[34];
            i_len_r  <= in_len[6:0];
            if (kind == tpq_pkg::KIND_PUSH) begin
              pend_r     <= 1'b0;
              pidx_r     <= '0;
              res_dest_r <= '0;
              res_prio_r <= '0;
              res_ack_r  <= 1'b0;
              res_len_r  <= '0;
              if (in_len > {1'b0, MAXP}) begin
                rej_r        <= rej_r + 32'd1;
                res_status_r <= tpq_pkg::ST_TOO_LONG;
              end
            end
            if (byte_wr) begin
              fill_r[pslot_r] <= pidx_r + 7'd1;
              if (pidx_r + 7'd1 >= plen_r) begin
                pend_r <= 1'b0;
                pidx_r <= '0;
              end else begin
                pidx_r <= pidx_r + 7'd1;
              end
            end
          end
        end
        S_SCAN: scan_i_r <= scan_i_r + SW'(1);
        S_DECIDE: begin
          k_r <= '0;
          if (!is_pop_r) begin
            if (push_ok) begin
              used_r[push_slot]  <= 1'b1;
              prio_r[push_slot]  <= i_prio_r;
              stamp_r[push_slot] <= arrival_r;
              dest_r[push_slot]  <= i_dest_r;
              ack_r[push_slot]   <= i_ack_r;
              len_r[push_slot]   <= i_len_r;
              fill_r[push_slot]  <= '0;
              arrival_r <= (arrival_r == 32'hFFFF_FFFF) ? 32'd1 : arrival_r + 32'd1;
              for (int j = 0; j < 3; j++) begin
                if (push_evict && s_w_prio == 2'(j)) cnt_r[j] <= cnt_r[j] - 7'd1;
                else if (i_prio_r == 2'(j))          cnt_r[j] <= cnt_r[j] + 7'd1;
              end
              if (push_evict) evc_r <= evc_r + 32'd1;
              res_status_r <= push_evict ? tpq_pkg::ST_EVICTED : tpq_pkg::ST_OK;
              if (i_len_r != 7'd0) begin
                pend_r  <= 1'b1;
                pslot_r <= push_slot;
                pidx_r  <= '0;
                plen_r  <= i_len_r;
              end
            end else begin
              rej_r        <= rej_r + 32'd1;
              res_status_r <= tpq_pkg::ST_FULL;
            end
          end else if (!s_any) begin
            res_status_r <= tpq_pkg::ST_EMPTY;
            res_dest_r   <= '0;
            res_prio_r   <= '0;
            res_ack_r    <= 1'b0;
            res_len_r    <= '0;
          end else begin
            used_r[s_b_idx] <= 1'b0;
            for (int j = 0; j < 3; j++)
              if (s_b_prio == 2'(j)) cnt_r[j] <= cnt_r[j] - 7'd1;
            if (pend_r && pslot_r == s_b_idx) begin
              pend_r <= 1'b0;
              pidx_r <= '0;
            end
            res_status_r <= tpq_pkg::ST_POPPED;
            res_dest_r   <= s_dest;
            res_prio_r   <= s_b_prio;
            res_ack_r    <= s_ack;
            res_len_r    <= s_len;
          end
        end
        S_LOAD: begin
          if (out_free) begin
            out_last_r  <= 1'b1;
            o_status_r  <= res_status_r;
            o_data_r    <= {1'b0, evc_r, rej_r, cnt_r[2], cnt_r[1], cnt_r[0], 8'd0,
                            res_len_r, res_ack_r, res_prio_r, res_dest_r};
          end
        end
        S_BYTE: begin
          if (out_free) begin
            out_last_r  <= (k_r + 7'd1 == s_len);
            o_status_r  <= res_status_r;
            o_data_r    <= {1'b0, evc_r, rej_r, cnt_r[2], cnt_r[1], cnt_r[0],
                            (k_r < s_fill) ? rd_byte : 8'd0,
                            res_len_r, res_ack_r, res_prio_r, res_dest_r};
            k_r <= k_r + 7'd1;
          end
        end
        S_RD, S_HOLD: ;
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = o_data_r;
  assign out_tuser  = o_status_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== hw/rtl/tpq_checker.sv =====
// Port-level checks for the priority transmit queue, bound to the top level.
module tpq_checker #(
  parameter int SLOTS = tpq_pkg::SLOTS_DEF
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [tpq_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [tpq_pkg::OUT_USER_W-1:0] out_tuser,
  input logic                           out_tlast
);

  logic [8:0] occ;
  assign occ = 9'(out_tdata[56:50]) + 9'(out_tdata[63:57]) + 9'(out_tdata[70:64]);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= tpq_pkg::ST_EMPTY)
    else $error("status code out of range");

  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != tpq_pkg::ST_POPPED |-> out_tlast)
    else $error("push or empty result without last");

  a_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> occ <= 9'(SLOTS))
    else $error("occupancy exceeds slot count");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == tpq_pkg::ST_EMPTY |-> occ == 9'd0)
    else $error("empty pop with occupied slots");

endmodule

bind priority_tx_queue_with_eviction tpq_checker #(.SLOTS(SLOTS)) u_tpq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the priority transmit queue with eviction.
`timescale 1ns / 1ps

module tb_top;

  localparam int NSLOT = 8;
  localparam int MAXPL = 32;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    tpq_pkg::kind_t kind;
    logic [31:0] dest;
    logic [1:0]  prio;
    logic        ack;
    logic [7:0]  len;
    logic [7:0]  data;
  } request_t;

  typedef struct packed {
    tpq_pkg::status_t status;
    logic [31:0] dest;
    logic [1:0]  prio;
    logic        ack;
    logic [6:0]  len;
    logic [7:0]  pbyte;
    logic        last;
    logic [6:0]  cnt_low;
    logic [6:0]  cnt_norm;
    logic [6:0]  cnt_high;
    logic [31:0] rejects;
    logic [31:0] evicts;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [tpq_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic [tpq_pkg::IN_USER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [tpq_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [tpq_pkg::OUT_USER_W-1:0] out_tuser;
  logic out_tlast;

  priority_tx_queue_with_eviction DUT (.*);

  always #2 clk = ~clk;

  // queue model state
  logic        q_used [NSLOT];
  logic [1:0]  q_prio [NSLOT];
  logic [31:0] q_stamp [NSLOT];
  logic [31:0] q_dest [NSLOT];
  logic        q_ack [NSLOT];
  logic [7:0]  q_len [NSLOT];
  logic [7:0]  q_pay [NSLOT][MAXPL];
  logic [31:0] arrival, rej_cnt, evict_cnt;
  bit          fill_open;
  int          fill_slot, fill_idx;

  request_t pending_reqs[$];
  result_t  expected_results[$];
  int errors = 0, n_results = 0, n_reqs = 0, cycles = 0;
  int idle_pct = 0, stall_pct = 0;
  bit stim_done = 0;

  task automatic report(input string msg);
    errors++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  function automatic void post(input tpq_pkg::status_t st, input logic [31:0] d,
                               input logic [1:0] p, input logic a, input logic [6:0] l,
                               input logic [7:0] b, input logic lst);
    result_t r;
    r = '0;
    r.status = st; r.dest = d; r.prio = p; r.ack = a; r.len = l; r.pbyte = b; r.last = lst;
    for (int i = 0; i < NSLOT; i++)
      if (q_used[i])
        case (q_prio[i])
          2'd0: r.cnt_low++;
          2'd1: r.cnt_norm++;
          default: r.cnt_high++;
        endcase
    r.rejects = rej_cnt;
    r.evicts = evict_cnt;
    expected_results.push_back(r);
  endfunction

  function automatic void queue_push(input request_t q);
    logic [1:0] p;
    int slot, w;
    bit ev;
    p = (q.prio > 2) ? 2'd2 : q.prio;
    slot = NSLOT; w = NSLOT; ev = 0;
    fill_open = 0; fill_idx = 0;
    if (q.len > MAXPL) begin
      rej_cnt++;
      post(tpq_pkg::ST_TOO_LONG, 0, 0, 0, 0, 0, 1);
      return;
    end
    for (int i = NSLOT - 1; i >= 0; i--) if (!q_used[i]) slot = i;
    if (slot == NSLOT) begin
      for (int i = 0; i < NSLOT; i++)
        if (q_used[i] && (w == NSLOT || q_prio[i] < q_prio[w] ||
            (q_prio[i] == q_prio[w] && q_stamp[i] < q_stamp[w]))) w = i;
      if (w == NSLOT || q_prio[w] >= p) begin
        rej_cnt++;
        post(tpq_pkg::ST_FULL, 0, 0, 0, 0, 0, 1);
        return;
      end
      q_used[w] = 0;
      evict_cnt++;
      ev = 1;
      slot = w;
    end
    for (int k = 0; k < MAXPL; k++) q_pay[slot][k] = 8'd0;
    q_dest[slot] = q.dest; q_prio[slot] = p; q_ack[slot] = q.ack;
    q_len[slot] = q.len; q_used[slot] = 1; q_stamp[slot] = arrival;
    arrival++;
    if (arrival == 0) arrival = 1;
    if (q.len > 0) begin
      fill_open = 1; fill_slot = slot; fill_idx = 0;
    end
    post(ev ? tpq_pkg::ST_EVICTED : tpq_pkg::ST_OK, 0, 0, 0, 0, 0, 1);
  endfunction

  function automatic void queue_pop();
    int b;
    b = NSLOT;
    for (int i = 0; i < NSLOT; i++)
      if (q_used[i] && (b == NSLOT || q_prio[i] > q_prio[b] ||
          (q_prio[i] == q_prio[b] && q_stamp[i] < q_stamp[b]))) b = i;
    if (b == NSLOT) begin
      post(tpq_pkg::ST_EMPTY, 0, 0, 0, 0, 0, 1);
      return;
    end
    q_used[b] = 0;
    if (fill_open && fill_slot == b) begin
      fill_open = 0; fill_idx = 0;
    end
    if (q_len[b] == 0) post(tpq_pkg::ST_POPPED, q_dest[b], q_prio[b], q_ack[b], 0, 0, 1);
    for (int k = 0; k < q_len[b]; k++)
      post(tpq_pkg::ST_POPPED, q_dest[b], q_prio[b], q_ack[b], q_len[b][6:0], q_pay[b][k],
           k + 1 == q_len[b]);
  endfunction

  function automatic void predict_request(input request_t q);
    case (q.kind)
      tpq_pkg::KIND_PUSH: queue_push(q);
      tpq_pkg::KIND_POP:  queue_pop();
      tpq_pkg::KIND_BYTE: begin
        if (fill_open && fill_idx < q_len[fill_slot]) begin
          q_pay[fill_slot][fill_idx] = q.data;
          fill_idx++;
          if (fill_idx >= q_len[fill_slot]) begin
            fill_open = 0; fill_idx = 0;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic request_t make_req(input tpq_pkg::kind_t k, input logic [31:0] d,
                                        input logic [1:0] p, input logic a,
                                        input logic [7:0] l, input logic [7:0] b);
    request_t q;
    q.kind = k; q.dest = d; q.prio = p; q.ack = a; q.len = l; q.data = b;
    return q;
  endfunction

  function automatic request_t rand_req(input tpq_pkg::kind_t k);
    return make_req(k, $urandom, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                    8'($urandom_range(0, 9) == 0 ? $urandom_range(0, 255) :
                       ($urandom_range(0, 4) == 0 ? $urandom_range(9, 32) :
                        $urandom_range(0, 8))),
                    8'($urandom));
  endfunction

  // well-formed message: header then all its bytes, sometimes cut short
  task automatic add_message();
    request_t h;
    int n;
    h = rand_req(tpq_pkg::KIND_PUSH);
    if (h.len > MAXPL) h.len = 8'($urandom_range(0, 8));
    pending_reqs.push_back(h);
    n = int'(h.len);
    if ($urandom_range(0, 7) == 0) n = $urandom_range(0, n);
    for (int i = 0; i < n; i++) pending_reqs.push_back(rand_req(tpq_pkg::KIND_BYTE));
  endtask

  // driver
  always @(posedge clk) begin
    request_t q;
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          q = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= q.kind;
          in_tdata <= {5'd0, q.data, q.len, q.ack, q.prio, q.dest};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // monitor: predict on input acceptance, compare on output acceptance
  always @(posedge clk) begin
    request_t q;
    result_t got, exp;
    cycles++;
    if (rst_n && in_tvalid && in_tready) begin
      q.kind = tpq_pkg::kind_t'(in_tuser);
      {q.data, q.len, q.ack, q.prio, q.dest} = in_tdata[50:0];
      predict_request(q);
      n_reqs++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.status = tpq_pkg::status_t'(out_tuser);
      {got.evicts, got.rejects, got.cnt_high, got.cnt_norm, got.cnt_low, got.pbyte,
       got.len, got.ack, got.prio, got.dest} = out_tdata[134:0];
      got.last = out_tlast;
      n_results++;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result status %0d", out_tuser));
      end else begin
        exp = expected_results.pop_front();
        if (got.status !== exp.status)
          report($sformatf("status got %0d exp %0d", got.status, exp.status));
        if (got.dest !== exp.dest) report($sformatf("dest got %h exp %h", got.dest, exp.dest));
        if (got.prio !== exp.prio) report($sformatf("prio got %0d exp %0d", got.prio, exp.prio));
        if (got.ack !== exp.ack) report($sformatf("ack got %0d exp %0d", got.ack, exp.ack));
        if (got.len !== exp.len) report($sformatf("len got %0d exp %0d", got.len, exp.len));
        if (got.pbyte !== exp.pbyte)
          report($sformatf("byte got %h exp %h", got.pbyte, exp.pbyte));
        if (got.last !== exp.last) report($sformatf("last got %0d exp %0d", got.last, exp.last));
        if (got.cnt_low !== exp.cnt_low || got.cnt_norm !== exp.cnt_norm ||
            got.cnt_high !== exp.cnt_high)
          report($sformatf("counts got %0d/%0d/%0d exp %0d/%0d/%0d", got.cnt_low,
                 got.cnt_norm, got.cnt_high, exp.cnt_low, exp.cnt_norm, exp.cnt_high));
        if (got.rejects !== exp.rejects)
          report($sformatf("rejects got %0d exp %0d", got.rejects, exp.rejects));
        if (got.evicts !== exp.evicts)
          report($sformatf("evicts got %0d exp %0d", got.evicts, exp.evicts));
      end
    end
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycles, expected_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int pr_idle[4];
    int pr_stall[4];
    pr_idle = '{0, 47, 0, 16};
    pr_stall = '{0, 0, 47, 16};
    for (int i = 0; i < NSLOT; i++) begin
      q_used[i] = 0; q_prio[i] = 0; q_stamp[i] = 0; q_dest[i] = 0; q_ack[i] = 0; q_len[i] = 0;
      for (int k = 0; k < MAXPL; k++) q_pay[i][k] = 0;
    end
    arrival = 1; rej_cnt = 0; evict_cnt = 0; fill_open = 0; fill_slot = 0; fill_idx = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty pop, stray byte, kind three, extremes, eviction, full, partial pop
    pending_reqs.push_back(make_req(tpq_pkg::KIND_POP, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(tpq_pkg::KIND_BYTE, 0, 0, 0, 0, 8'hff));
    pending_reqs.push_back(make_req(tpq_pkg::KIND_NONE, '1, 3, 1, 255, 255));
    pending_reqs.push_back(make_req(tpq_pkg::KIND_PUSH, '1, 3, 1, 33, 0));
    pending_reqs.push_back(make_req(tpq_pkg::KIND_PUSH, '1, 3, 1, 255, 0));
    pending_reqs.push_back(make_req(tpq_pkg::KIND_PUSH, '1, 0, 1, 32, 0));
    pending_reqs.push_back(make_req(tpq_pkg::KIND_BYTE, 0, 0, 0, 0, 8'hff));
    pending_reqs.push_back(make_req(tpq_pkg::KIND_BYTE, 0, 0, 0, 0, 8'h00));
    pending_reqs.push_back(make_req(tpq_pkg::KIND_PUSH, 0, 1, 0, 0, 0));
    for (int i = 0; i < 6; i++)
      pending_reqs.push_back(make_req(tpq_pkg::KIND_PUSH, i, 0, i[0], 1, 0));
    pending_reqs.push_back(make_req(tpq_pkg::KIND_PUSH, 32'h55, 0, 0, 2, 0));
    pending_reqs.push_back(make_req(tpq_pkg::KIND_PUSH, 32'h66, 1, 1, 2, 0));
    pending_reqs.push_back(make_req(tpq_pkg::KIND_BYTE, 0, 0, 0, 0, 8'ha5));
    pending_reqs.push_back(make_req(tpq_pkg::KIND_PUSH, 32'h77, 3, 0, 0, 0));
    for (int i = 0; i < 6; i++)
      pending_reqs.push_back(make_req(tpq_pkg::KIND_POP, 0, 0, 0, 0, 0));

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = pr_idle[ph];
      stall_pct = pr_stall[ph];
      for (int n = 0; n < 20; ) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: add_message();
          4, 5, 6: pending_reqs.push_back(make_req(tpq_pkg::KIND_POP, 0, 0, 0, 0, 0));
          7: pending_reqs.push_back(rand_req(tpq_pkg::KIND_PUSH));
          8: pending_reqs.push_back(rand_req(tpq_pkg::KIND_BYTE));
          default: pending_reqs.push_back(rand_req(tpq_pkg::kind_t'($urandom_range(0, 3))));
        endcase
        n++;
      end
      // drain before the next idling mix
      while (pending_reqs.size() > 0 || expected_results.size() > 0) @(posedge clk);
    end
    // drain the queue
    for (int i = 0; i < NSLOT + 1; i++)
      pending_reqs.push_back(make_req(tpq_pkg::KIND_POP, 0, 0, 0, 0, 0));
    while (pending_reqs.size() > 0 || in_tvalid || expected_results.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Covered %0d requests and %0d results over four idling mixes", n_reqs, n_results);
    $display("Final counters: %0d rejected, %0d evicted", rej_cnt, evict_cnt);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
